/* rtl/core/assert_macros.svh */
// Assertion macros shared by the splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(name, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

/* rtl/core/wcs_pkg.sv */
// Types, codes and constants of the code-section instruction splitter.
`default_nettype none

package wcs_pkg;

  localparam int unsigned OutFifoDepth = 4;

  localparam logic [3:0] HeaderLen   = 4'd8;
  localparam logic [7:0] CodeSecId   = 8'd10;
  localparam logic [7:0] OpI32Const  = 8'h41;
  localparam logic [7:0] OpLocalGet  = 8'h20;
  localparam logic [7:0] OpLocalSet  = 8'h21;
  localparam logic [7:0] OpLocalTee  = 8'h22;
  localparam logic [7:0] OpCall      = 8'h10;
  localparam logic [7:0] OpIf        = 8'h04;
  localparam logic [7:0] LenMax      = 8'hFF;
  localparam logic [5:0] LebStep     = 6'd7;
  localparam logic [5:0] LebLimit    = 6'd32;

  localparam logic       KindInstr   = 1'b0;
  localparam logic       KindFinish  = 1'b1;

  localparam logic [1:0] FinParsed   = 2'd0;
  localparam logic [1:0] FinNoCode   = 2'd1;
  localparam logic [1:0] FinEmpty    = 2'd2;

  typedef enum logic [13:0] {
    PhHeader    = 14'b00000000000001,
    PhSecId     = 14'b00000000000010,
    PhSecSize   = 14'b00000000000100,
    PhSecSkip   = 14'b00000000001000,
    PhCodeSize  = 14'b00000000010000,
    PhFuncCount = 14'b00000000100000,
    PhBodySize  = 14'b00000001000000,
    PhLocalCnt  = 14'b00000010000000,
    PhLocalN    = 14'b00000100000000,
    PhLocalType = 14'b00001000000000,
    PhOpcode    = 14'b00010000000000,
    PhImm       = 14'b00100000000000,
    PhBlock     = 14'b01000000000000,
    PhDone      = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_module;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  op_byte;
    logic [31:0] immediate;
    logic [7:0]  instr_length;
    logic [31:0] instr_offset;
    logic [1:0]  finish_code;
  } out_item_t;

  typedef struct packed {
    logic      ins_valid;
    logic      fin_valid;
    out_item_t ins;
    out_item_t fin;
  } step_res_t;

  function automatic logic takes_leb(input logic [7:0] op);
    takes_leb = (op == OpI32Const) || (op == OpLocalGet) || (op == OpLocalSet) ||
                (op == OpLocalTee) || (op == OpCall);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wcs_parser.sv */
// Byte-level section walker and instruction splitter state machine.
`default_nettype none

module wcs_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire wcs_pkg::in_item_t in_i,
  output wcs_pkg::step_res_t     res_o
);

  `include "assert_macros.svh"

  wcs_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_q, hdr_d;
  logic [31:0] leb_acc_q, leb_acc_d;
  logic [5:0]  leb_shift_q, leb_shift_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] body_q, body_d;
  logic [31:0] locals_q, locals_d;
  logic [7:0]  pend_op_q, pend_op_d;
  logic [7:0]  pend_len_q, pend_len_d;
  logic [31:0] pend_off_q, pend_off_d;
  logic [31:0] pos_q, pos_d;
  logic        open_q, open_d;

  logic [7:0]  b;
  logic        last;
  logic        region;
  logic        leb_room;
  logic [31:0] leb_acc_take;
  logic [5:0]  leb_shift_take;
  logic        leb_done;
  logic [31:0] body_sat;
  logic [31:0] locals_dec;
  logic [7:0]  len_grow;
  logic [3:0]  hdr_inc;
  logic        ins_valid;
  logic        fin_valid;
  logic [31:0] ins_imm;
  logic [1:0]  fin_code;

  always_comb begin
    b              = in_i.data_byte;
    last           = in_i.end_of_module;
    leb_room       = leb_shift_q < wcs_pkg::LebLimit;
    leb_acc_take   = leb_room ? (leb_acc_q | (32'(b[6:0]) << leb_shift_q)) : leb_acc_q;
    leb_shift_take = leb_room ? (leb_shift_q + wcs_pkg::LebStep) : leb_shift_q;
    leb_done       = ~b[7];
    body_sat       = (body_q != 32'd0) ? (body_q - 32'd1) : body_q;
    locals_dec     = locals_q - 32'd1;
    len_grow       = (pend_len_q < wcs_pkg::LenMax) ? (pend_len_q + 8'd1) : pend_len_q;
    hdr_inc        = hdr_q + 4'd1;

    phase_d     = phase_q;
    hdr_d       = hdr_q;
    leb_acc_d   = leb_acc_q;
    leb_shift_d = leb_shift_q;
    skip_d      = skip_q;
    body_d      = body_q;
    locals_d    = locals_q;
    pend_op_d   = pend_op_q;
    pend_len_d  = pend_len_q;
    pend_off_d  = pend_off_q;
    pos_d       = pos_q;
    open_d      = open_q;
    region      = 1'b0;
    ins_valid   = 1'b0;
    fin_valid   = 1'b0;
    ins_imm     = 32'd0;
    fin_code    = wcs_pkg::FinParsed;

    if (step_i) begin
      case (phase_q)
        wcs_pkg::PhHeader: begin
          hdr_d = hdr_inc;
          if (hdr_inc >= wcs_pkg::HeaderLen) begin
            phase_d = wcs_pkg::PhSecId;
          end
        end
        wcs_pkg::PhSecId: begin
          leb_acc_d   = 32'd0;
          leb_shift_d = 6'd0;
          phase_d     = (b == wcs_pkg::CodeSecId) ? wcs_pkg::PhCodeSize : wcs_pkg::PhSecSize;
        end
        wcs_pkg::PhSecSize: begin
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            skip_d  = leb_acc_take;
            phase_d = (leb_acc_take == 32'd0) ? wcs_pkg::PhSecId : wcs_pkg::PhSecSkip;
          end
        end
        wcs_pkg::PhSecSkip: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = wcs_pkg::PhSecId;
          end
        end
        wcs_pkg::PhCodeSize, wcs_pkg::PhFuncCount: begin
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            leb_acc_d   = 32'd0;
            leb_shift_d = 6'd0;
            phase_d     = (phase_q == wcs_pkg::PhCodeSize) ? wcs_pkg::PhFuncCount
                                                          : wcs_pkg::PhBodySize;
          end
        end
        wcs_pkg::PhBodySize: begin
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            body_d      = leb_acc_take;
            leb_acc_d   = 32'd0;
            leb_shift_d = 6'd0;
            phase_d     = wcs_pkg::PhLocalCnt;
          end
        end
        wcs_pkg::PhLocalCnt: begin
          body_d      = body_sat;
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            locals_d    = leb_acc_take;
            leb_acc_d   = 32'd0;
            leb_shift_d = 6'd0;
            if (leb_acc_take == 32'd0) begin
              if (body_sat <= 32'd1) begin
                fin_valid = 1'b1;
                fin_code  = wcs_pkg::FinEmpty;
                phase_d   = wcs_pkg::PhDone;
              end else begin
                body_d  = body_sat - 32'd1;
                pos_d   = 32'd0;
                phase_d = wcs_pkg::PhOpcode;
              end
            end else begin
              phase_d = wcs_pkg::PhLocalN;
            end
          end
        end
        wcs_pkg::PhLocalN: begin
          body_d      = body_sat;
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            leb_acc_d   = 32'd0;
            leb_shift_d = 6'd0;
            phase_d     = wcs_pkg::PhLocalType;
          end
        end
        wcs_pkg::PhLocalType: begin
          body_d   = body_sat;
          locals_d = locals_dec;
          if (locals_dec == 32'd0) begin
            if (body_sat <= 32'd1) begin
              fin_valid = 1'b1;
              fin_code  = wcs_pkg::FinEmpty;
              phase_d   = wcs_pkg::PhDone;
            end else begin
              body_d  = body_sat - 32'd1;
              pos_d   = 32'd0;
              phase_d = wcs_pkg::PhOpcode;
            end
          end else begin
            phase_d = wcs_pkg::PhLocalN;
          end
        end
        wcs_pkg::PhOpcode: begin
          region      = 1'b1;
          pend_op_d   = b;
          pend_len_d  = 8'd1;
          pend_off_d  = pos_q;
          leb_acc_d   = 32'd0;
          leb_shift_d = 6'd0;
          if (wcs_pkg::takes_leb(b)) begin
            open_d  = 1'b1;
            phase_d = wcs_pkg::PhImm;
          end else if (b == wcs_pkg::OpIf) begin
            open_d  = 1'b1;
            phase_d = wcs_pkg::PhBlock;
          end else begin
            ins_valid = 1'b1;
            open_d    = 1'b0;
          end
        end
        wcs_pkg::PhImm: begin
          region      = 1'b1;
          pend_len_d  = len_grow;
          leb_acc_d   = leb_acc_take;
          leb_shift_d = leb_shift_take;
          if (leb_done) begin
            ins_valid = 1'b1;
            ins_imm   = leb_acc_take;
            open_d    = 1'b0;
            phase_d   = wcs_pkg::PhOpcode;
          end
        end
        wcs_pkg::PhBlock: begin
          region     = 1'b1;
          pend_len_d = len_grow;
          ins_valid  = 1'b1;
          ins_imm    = 32'(b);
          open_d     = 1'b0;
          phase_d    = wcs_pkg::PhOpcode;
        end
        default: begin
        end
      endcase

      if (region) begin
        pos_d  = pos_q + 32'd1;
        body_d = body_q - 32'd1;
        if ((body_q == 32'd1) || last) begin
          if (open_d) begin
            ins_valid = 1'b1;
            ins_imm   = (phase_d == wcs_pkg::PhImm) ? leb_acc_d : 32'd0;
            open_d    = 1'b0;
          end
          fin_valid = 1'b1;
          fin_code  = wcs_pkg::FinParsed;
          phase_d   = wcs_pkg::PhDone;
        end
      end else if (last && (phase_d != wcs_pkg::PhDone)) begin
        fin_valid = 1'b1;
        fin_code  = wcs_pkg::FinNoCode;
        phase_d   = wcs_pkg::PhDone;
      end
    end

    res_o.ins_valid        = ins_valid;
    res_o.fin_valid        = fin_valid;
    res_o.ins.item_kind    = wcs_pkg::KindInstr;
    res_o.ins.op_byte      = pend_op_d;
    res_o.ins.immediate    = ins_imm;
    res_o.ins.instr_length = pend_len_d;
    res_o.ins.instr_offset = pend_off_d;
    res_o.ins.finish_code  = wcs_pkg::FinParsed;
    res_o.fin.item_kind    = wcs_pkg::KindFinish;
    res_o.fin.op_byte      = 8'd0;
    res_o.fin.immediate    = 32'd0;
    res_o.fin.instr_length = 8'd0;
    res_o.fin.instr_offset = 32'd0;
    res_o.fin.finish_code  = fin_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wcs_pkg::PhHeader;
      hdr_q       <= 4'd0;
      leb_acc_q   <= 32'd0;
      leb_shift_q <= 6'd0;
      skip_q      <= 32'd0;
      body_q      <= 32'd0;
      locals_q    <= 32'd0;
      pend_op_q   <= 8'd0;
      pend_len_q  <= 8'd0;
      pend_off_q  <= 32'd0;
      pos_q       <= 32'd0;
      open_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      leb_acc_q   <= leb_acc_d;
      leb_shift_q <= leb_shift_d;
      skip_q      <= skip_d;
      body_q      <= body_d;
      locals_q    <= locals_d;
      pend_op_q   <= pend_op_d;
      pend_len_q  <= pend_len_d;
      pend_off_q  <= pend_off_d;
      pos_q       <= pos_d;
      open_q      <= open_d;
    end
  end

  `ASSERT_RST(a_done_silent, clk_i, rst_ni, (phase_q == wcs_pkg::PhDone) |-> (!res_o.ins_valid && !res_o.fin_valid), "results after finish")
  `ASSERT_RST(a_finish_ends, clk_i, rst_ni, res_o.fin_valid |=> (phase_q == wcs_pkg::PhDone), "finish did not end the run")
  `ASSERT_RST(a_open_phase, clk_i, rst_ni, open_q |-> ((phase_q == wcs_pkg::PhImm) || (phase_q == wcs_pkg::PhBlock)), "open instruction outside immediate phases")

endmodule

`default_nettype wire

/* rtl/core/wcs_out_fifo.sv */
// Result queue that takes up to two items per cycle and hands out one per cycle while the output is not stalled.
`default_nettype none

module wcs_out_fifo #(
  parameter int unsigned Depth = wcs_pkg::OutFifoDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wcs_pkg::step_res_t push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output wcs_pkg::out_item_t      out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : (p + 1'b1);
  endfunction

  wcs_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr_next;
  logic            push_any;
  logic            push_two;
  logic            pop;
  wcs_pkg::out_item_t first_item;

  always_comb begin
    push_any    = push_i.ins_valid | push_i.fin_valid;
    push_two    = push_i.ins_valid & push_i.fin_valid;
    first_item  = push_i.ins_valid ? push_i.ins : push_i.fin;
    wr_ptr_next = ptr_inc(wr_ptr_q);
    pop         = (count_q != '0) && !out_stall_i;
    wr_ptr_d    = push_two ? ptr_inc(wr_ptr_next) : (push_any ? wr_ptr_next : wr_ptr_q);
    rd_ptr_d    = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d     = count_q + CntW'(push_any) + CntW'(push_two) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_any) begin
      mem_q[wr_ptr_q] <= first_item;
    end
    if (push_two) begin
      mem_q[wr_ptr_next] <= push_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign room_o      = count_q <= CntW'(Depth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "queue count beyond depth")
  `ASSERT_RST(a_push_room, clk_i, rst_ni, push_any |-> room_o, "push without room for two")
  `ASSERT_RST(a_pop_only, clk_i, rst_ni, (pop && !push_any) |=> (count_q == $past(count_q) - 1'b1), "lone pop")

endmodule

`default_nettype wire

/* rtl/core/wasm_code_section_instruction_splitter.sv */
// Top level of the WebAssembly code-section instruction splitter.
`default_nettype none

// Takes one module byte per cycle and keeps taking one per cycle for as long as results are
// drained. A byte is held in the input register, then the parser state machine handles it
// and writes its results into an OutDepth-entry result queue, which hands them out in order.
// Input is held off only while the queue has fewer than two free places. With results taken
// as they appear the queue never holds more than two, so bytes flow without a gap; a long
// downstream stall fills the queue and then holds the input until results are taken again.
// After the finish item every further byte is transferred and dropped until reset.
module wasm_code_section_instruction_splitter #(
  parameter int unsigned OutDepth = wcs_pkg::OutFifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire wcs_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wcs_pkg::out_item_t     out_data_o
);

  logic              in_valid_q, in_valid_d;
  wcs_pkg::in_item_t in_q;
  logic              room;
  logic              step;
  logic              accept;
  wcs_pkg::step_res_t res;

  assign step       = in_valid_q & room;
  assign in_stall_o = in_valid_q & ~room;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_valid_d = accept | (in_valid_q & ~step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  wcs_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_q),
    .res_o  (res)
  );

  wcs_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* verif/tb_wasm_code_section_instruction_splitter.sv */
// Testbench of the code-section instruction splitter: one module stream, every result predicted.
module tb_wasm_code_section_instruction_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit   = 1000;
  localparam int TailBytes    = 5;
  localparam int RegionTarget = 1200;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  wcs_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  wcs_pkg::out_item_t out_data_o;

  wcs_pkg::in_item_t  byte_q[$];
  wcs_pkg::out_item_t parsed_items_q[$];
  logic [7:0]         build_q[$];
  logic [7:0]         leb_ops [5] = '{wcs_pkg::OpI32Const, wcs_pkg::OpLocalGet,
                                      wcs_pkg::OpLocalSet, wcs_pkg::OpLocalTee,
                                      wcs_pkg::OpCall};

  int total_bytes = 0;
  int drain_mark  = 0;
  int fed_cnt     = 0;
  int instr_cnt   = 0;
  int finish_cnt  = 0;
  int bad_cnt     = 0;
  int quiet       = 0;
  bit in_took     = 1'b0;
  bit drain_done  = 1'b0;

  wcs_pkg::phase_e p_phase = wcs_pkg::PhHeader;
  logic [3:0]  hdr_cnt     = '0;
  logic [31:0] leb_val     = '0;
  logic [5:0]  leb_sh      = '0;
  logic [31:0] sec_left    = '0;
  logic [31:0] body_left   = '0;
  logic [31:0] locals_left = '0;
  logic [7:0]  op_q        = '0;
  logic [7:0]  len_q       = '0;
  logic [31:0] off_q       = '0;
  logic [31:0] region_pos  = '0;
  logic        open_q      = 1'b0;

  wasm_code_section_instruction_splitter DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void put_byte(input logic [7:0] b);
    build_q = {build_q, b};
  endfunction

  function automatic void leb_reset();
    leb_val = '0;
    leb_sh  = '0;
  endfunction

  function automatic logic leb_add(input logic [7:0] b);
    if (leb_sh < wcs_pkg::LebLimit) begin
      leb_val = leb_val | ({25'd0, b[6:0]} << leb_sh);
      leb_sh  = leb_sh + wcs_pkg::LebStep;
    end
    return !b[7];
  endfunction

  function automatic void body_dec();
    if (body_left != 0) body_left = body_left - 1;
  endfunction

  task automatic push_instr(input logic [31:0] imm);
    wcs_pkg::out_item_t r;
    r              = '0;
    r.item_kind    = wcs_pkg::KindInstr;
    r.op_byte      = op_q;
    r.immediate    = imm;
    r.instr_length = len_q;
    r.instr_offset = off_q;
    r.finish_code  = wcs_pkg::FinParsed;
    parsed_items_q = {parsed_items_q, r};
    open_q = 1'b0;
  endtask

  task automatic push_finish(input logic [1:0] code);
    wcs_pkg::out_item_t r;
    r              = '0;
    r.item_kind    = wcs_pkg::KindFinish;
    r.finish_code  = code;
    parsed_items_q = {parsed_items_q, r};
    p_phase = wcs_pkg::PhDone;
  endtask

  task automatic locals_end();
    if (body_left <= 1) begin
      push_finish(wcs_pkg::FinEmpty);
    end else begin
      body_left  = body_left - 1;
      region_pos = '0;
      p_phase    = wcs_pkg::PhOpcode;
    end
  endtask

  task automatic parse_module_byte(input wcs_pkg::in_item_t it);
    logic [7:0] b;
    logic       in_region;
    b = it.data_byte;
    in_region = 1'b0;
    case (p_phase)
      wcs_pkg::PhHeader: begin
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= wcs_pkg::HeaderLen) p_phase = wcs_pkg::PhSecId;
      end
      wcs_pkg::PhSecId: begin
        leb_reset();
        if (b == wcs_pkg::CodeSecId) p_phase = wcs_pkg::PhCodeSize;
        else p_phase = wcs_pkg::PhSecSize;
      end
      wcs_pkg::PhSecSize: begin
        if (leb_add(b)) begin
          sec_left = leb_val;
          if (sec_left == 0) p_phase = wcs_pkg::PhSecId;
          else p_phase = wcs_pkg::PhSecSkip;
        end
      end
      wcs_pkg::PhSecSkip: begin
        sec_left = sec_left - 1;
        if (sec_left == 0) p_phase = wcs_pkg::PhSecId;
      end
      wcs_pkg::PhCodeSize: begin
        if (leb_add(b)) begin
          leb_reset();
          p_phase = wcs_pkg::PhFuncCount;
        end
      end
      wcs_pkg::PhFuncCount: begin
        if (leb_add(b)) begin
          leb_reset();
          p_phase = wcs_pkg::PhBodySize;
        end
      end
      wcs_pkg::PhBodySize: begin
        if (leb_add(b)) begin
          body_left = leb_val;
          leb_reset();
          p_phase = wcs_pkg::PhLocalCnt;
        end
      end
      wcs_pkg::PhLocalCnt: begin
        body_dec();
        if (leb_add(b)) begin
          locals_left = leb_val;
          leb_reset();
          if (locals_left == 0) locals_end();
          else p_phase = wcs_pkg::PhLocalN;
        end
      end
      wcs_pkg::PhLocalN: begin
        body_dec();
        if (leb_add(b)) begin
          leb_reset();
          p_phase = wcs_pkg::PhLocalType;
        end
      end
      wcs_pkg::PhLocalType: begin
        body_dec();
        locals_left = locals_left - 1;
        if (locals_left == 0) locals_end();
        else p_phase = wcs_pkg::PhLocalN;
      end
      wcs_pkg::PhOpcode: begin
        in_region = 1'b1;
        op_q  = b;
        len_q = 8'd1;
        off_q = region_pos;
        leb_reset();
        if (b == wcs_pkg::OpI32Const || b == wcs_pkg::OpLocalGet ||
            b == wcs_pkg::OpLocalSet || b == wcs_pkg::OpLocalTee ||
            b == wcs_pkg::OpCall) begin
          open_q  = 1'b1;
          p_phase = wcs_pkg::PhImm;
        end else if (b == wcs_pkg::OpIf) begin
          open_q  = 1'b1;
          p_phase = wcs_pkg::PhBlock;
        end else begin
          push_instr('0);
        end
      end
      wcs_pkg::PhImm: begin
        in_region = 1'b1;
        if (len_q < wcs_pkg::LenMax) len_q = len_q + 8'd1;
        if (leb_add(b)) begin
          push_instr(leb_val);
          p_phase = wcs_pkg::PhOpcode;
        end
      end
      wcs_pkg::PhBlock: begin
        in_region = 1'b1;
        if (len_q < wcs_pkg::LenMax) len_q = len_q + 8'd1;
        push_instr({24'd0, b});
        p_phase = wcs_pkg::PhOpcode;
      end
      default: ;
    endcase

    if (in_region) begin
      region_pos = region_pos + 1;
      body_left  = body_left - 1;
      if (body_left == 0 || it.end_of_module) begin
        if (open_q) push_instr((p_phase == wcs_pkg::PhImm) ? leb_val : 32'd0);
        push_finish(wcs_pkg::FinParsed);
      end
    end else if (it.end_of_module && p_phase != wcs_pkg::PhDone) begin
      push_finish(wcs_pkg::FinNoCode);
    end
  endtask

  task automatic add_leb(input logic [31:0] v, input int extra, input bit junk);
    int          n;
    logic [31:0] rest;
    logic [7:0]  chunk;
    n    = 1;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    n = n + extra;
    for (int i = 0; i < n; i++) begin
      if (i < 5) chunk = {1'b0, 7'(v >> (7 * i))};
      else chunk = junk ? {1'b0, 7'($urandom_range(127))} : 8'h00;
      if (i == 4 && junk) chunk[6:4] = 3'($urandom_range(7));
      chunk[7] = (i < n - 1);
      put_byte(chunk);
    end
  endtask

  always @(posedge clk_i) begin : watch
    wcs_pkg::out_item_t want;
    bit                 out_took;
    in_took  = rst_ni && in_valid_i && !in_stall_o;
    out_took = rst_ni && out_valid_o && !out_stall_i;
    if (in_took) begin
      fed_cnt++;
      parse_module_byte(in_data_i);
    end
    if (out_took) begin
      if (parsed_items_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected result: kind %0d op %h imm %h len %0d off %0d code %0d",
                   out_data_o.item_kind, out_data_o.op_byte, out_data_o.immediate,
                   out_data_o.instr_length, out_data_o.instr_offset, out_data_o.finish_code);
      end else begin
        want = parsed_items_q.pop_front();
        if (want.item_kind == wcs_pkg::KindFinish) finish_cnt++;
        else instr_cnt++;
        if (out_data_o.item_kind !== want.item_kind || out_data_o.op_byte !== want.op_byte ||
            out_data_o.immediate !== want.immediate ||
            out_data_o.instr_length !== want.instr_length ||
            out_data_o.instr_offset !== want.instr_offset ||
            out_data_o.finish_code !== want.finish_code) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("result %0d mismatch: want kind %0d op %h imm %h len %0d off %0d code %0d",
                     instr_cnt + finish_cnt, want.item_kind, want.op_byte, want.immediate,
                     want.instr_length, want.instr_offset, want.finish_code);
            $display("  got kind %0d op %h imm %h len %0d off %0d code %0d",
                     out_data_o.item_kind, out_data_o.op_byte, out_data_o.immediate,
                     out_data_o.instr_length, out_data_o.instr_offset, out_data_o.finish_code);
          end
        end
      end
    end
    if (in_took || out_took || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin : drive
    int idle_pct;
    int stall_pct;
    idle_pct  = (fed_cnt < total_bytes / 3) ? 10 : (fed_cnt < 2 * total_bytes / 3) ? 81 : 0;
    stall_pct = (fed_cnt < total_bytes / 3) ? 81 : (fed_cnt < 2 * total_bytes / 3) ? 10 : 0;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (in_valid_i && !in_took) begin
        // hold the stalled transfer
      end else if (!drain_done && total_bytes != 0 && fed_cnt >= drain_mark) begin
        in_valid_i <= 1'b0;
        if (parsed_items_q.size() == 0) drain_done = 1'b1;
      end else if (byte_q.size() == 0 || $urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]        body[$];
    logic [31:0]       v;
    int                r;
    wcs_pkg::in_item_t it;

    // locals: three groups, long and padded counts
    add_leb(32'd3, 1, 1'b0);
    add_leb(32'hFFFF_FFFF, 0, 1'b0);
    put_byte(8'h7F);
    add_leb(32'd1, 0, 1'b0);
    put_byte(8'h7E);
    add_leb(32'd2, 5, 1'b1);
    put_byte(8'($urandom_range(255)));

    put_byte(wcs_pkg::OpI32Const);
    add_leb(32'hFFFF_FFFF, 0, 1'b0);
    put_byte(wcs_pkg::OpLocalGet);
    add_leb(32'd0, 0, 1'b0);
    put_byte(wcs_pkg::OpLocalSet);
    add_leb(32'h1234_5678, 2, 1'b1);
    put_byte(wcs_pkg::OpLocalTee);
    add_leb(32'd127, 0, 1'b0);
    put_byte(wcs_pkg::OpCall);
    add_leb(32'd128, 0, 1'b0);
    put_byte(wcs_pkg::OpIf);
    put_byte(8'h40);
    put_byte(wcs_pkg::OpIf);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h0B);
    put_byte(wcs_pkg::OpI32Const);
    add_leb($urandom(), 262, 1'b1);

    while (build_q.size() < RegionTarget) begin
      r = $urandom_range(99);
      if (r < 45) begin
        put_byte(leb_ops[$urandom_range(4)]);
        v = $urandom() >> $urandom_range(31);
        add_leb(v, ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0, 1'b1);
      end else if (r < 55) begin
        put_byte(wcs_pkg::OpIf);
        put_byte(8'($urandom_range(255)));
      end else begin
        put_byte(8'($urandom_range(255)));
      end
    end

    // cut the region inside an immediate, then the body's final byte
    put_byte(wcs_pkg::OpLocalTee);
    put_byte(8'h80);
    put_byte(8'h81);
    put_byte(8'h0B);
    body = build_q;
    build_q.delete();

    for (int i = 0; i < wcs_pkg::HeaderLen; i++) put_byte(8'($urandom_range(255)));
    put_byte(8'h00);
    add_leb(32'd0, 0, 1'b0);
    put_byte(8'h01);
    add_leb(32'd3, 5, 1'b1);
    put_byte(wcs_pkg::CodeSecId);
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    put_byte(8'hFF);
    add_leb(32'd2, 0, 1'b0);
    put_byte(wcs_pkg::CodeSecId);
    put_byte(wcs_pkg::CodeSecId);
    put_byte(wcs_pkg::CodeSecId);
    add_leb(body.size() + 4, 3, 1'b1);
    add_leb(32'd1, 0, 1'b0);
    add_leb(body.size(), 2, 1'b0);
    build_q = {build_q, body};
    for (int i = 0; i < TailBytes; i++) put_byte(8'($urandom_range(255)));

    foreach (build_q[i]) begin
      it.data_byte     = build_q[i];
      it.end_of_module = (i == build_q.size() - 1) ||
                         (i >= build_q.size() - TailBytes && $urandom_range(1) == 1);
      byte_q = {byte_q, it};
    end
    drain_mark  = byte_q.size() / 2;
    total_bytes = byte_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_valid_i || parsed_items_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("summary: %0d module bytes through three pacing regimes and one drain pause",
             fed_cnt);
    $display("summary: %0d instruction items and %0d finish item checked, %0d failures",
             instr_cnt, finish_cnt, bad_cnt);
    if (bad_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wcs_pkg.sv
rtl/core/wcs_parser.sv
rtl/core/wcs_out_fifo.sv
rtl/core/wasm_code_section_instruction_splitter.sv
verif/tb_wasm_code_section_instruction_splitter.sv
